### sv/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg: shared types and constants for the seven-segment scan driver
// Holds operation codes, register indexes, clamp limits, the segment
// decode function and the structs passed between pipeline stages.
// ----------------------------------------------------------------------------
package sssd_pkg;

	// Largest display supported by this build (2..4)
	localparam int MaxDigits = 4;

	// Operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_SET_NUMBER = 2'd1,
		OP_SET_TIME   = 2'd2,
		OP_CLEAR      = 2'd3
	} op_t;

	// Configuration register indexes
	localparam int CfgIndexW = 8;
	localparam logic [CfgIndexW-1:0] REG_FOUR_DIGIT_MODE    = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_SHOW_LEADING_ZEROS = 8'd1;
	localparam logic [CfgIndexW-1:0] REG_COMMON_CATHODE     = 8'd2;
	localparam logic [CfgIndexW-1:0] REG_SCAN_INTERVAL      = 8'd3;

	// Clamp limits
	localparam logic [13:0] NumLimitFour = 14'd9999;
	localparam logic [13:0] NumLimitTwo  = 14'd99;
	localparam logic [7:0]  HoursLimit   = 8'd23;
	localparam logic [7:0]  MinutesLimit = 8'd59;

	// Reset values of the configuration registers
	localparam logic [15:0] ScanIntervalReset = 16'd1000;

	typedef logic [3:0] bcd_t;

	typedef struct packed {
		logic        four_digit_mode;
		logic        show_leading_zeros;
		logic        common_cathode;
		logic [15:0] scan_interval;
	} cfg_t;

	// Value split into a hundreds pair and a units pair (each 0..99)
	typedef struct packed {
		op_t        op;
		logic [6:0] hi;
		logic [6:0] lo;
	} pair_t;

	typedef struct packed {
		logic [6:0] segment;
		logic [3:0] lines;
		logic [1:0] position;
	} result_t;

	// Four digits only when selected and the build supports them
	function automatic logic four_digits(input cfg_t c);
		return c.four_digit_mode && (MaxDigits >= 4);
	endfunction

	// Split 0..99 into {tens, ones}; x*103 >> 10 is exact for this range
	function automatic logic [7:0] split_tens(input logic [6:0] x);
		logic [13:0] prod;
		logic [3:0]  tens;
		logic [6:0]  ones;
		prod = 14'(x) * 14'd103;
		tens = prod[13:10];
		ones = x - 7'(tens) * 7'd10;
		return {tens, ones[3:0]};
	endfunction

	// Segment pattern, bit 0 = a .. bit 6 = g
	function automatic logic [6:0] seg_pattern(input bcd_t d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h3F;
			4'd1: p = 7'h06;
			4'd2: p = 7'h5B;
			4'd3: p = 7'h4F;
			4'd4: p = 7'h66;
			4'd5: p = 7'h6D;
			4'd6: p = 7'h7D;
			4'd7: p = 7'h07;
			4'd8: p = 7'h7F;
			4'd9: p = 7'h6F;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

endpackage

### sv/sssd_prep.sv
// ----------------------------------------------------------------------------
// sssd_prep: input register and value clamp/split stage
// Registers each accepted transaction, clamps the number or the time and
// splits it into a hundreds pair and a units pair for the scan stage.
// ----------------------------------------------------------------------------
module sssd_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            in_valid,
	input  logic [1:0]      operation,
	input  logic [15:0]     number_value,
	input  logic [7:0]      hours_value,
	input  logic [7:0]      minutes_value,
	input  sssd_pkg::cfg_t  cfg,
	output logic            pair_valid,
	output sssd_pkg::pair_t pair
);
	import sssd_pkg::*;

	// 5243 / 2^19 approximates 1/100 closely enough for values below 16384
	localparam logic [13:0] RecipHundred = 14'd5243;
	localparam int          RecipShift   = 19;

	logic        valid_s1;
	op_t         op_s1;
	logic [15:0] num_s1;
	logic [7:0]  hrs_s1;
	logic [7:0]  min_s1;

	logic        valid_s2;
	pair_t       pair_s2;

	logic [13:0] num_lim;
	logic [13:0] num_cl;
	logic [27:0] prod;
	logic [6:0]  hundreds;
	logic [13:0] rem_full;
	logic [7:0]  hrs_cl;
	logic [7:0]  min_cl;
	pair_t       pair_d;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			op_s1  <= op_t'(operation);
			num_s1 <= number_value;
			hrs_s1 <= hours_value;
			min_s1 <= minutes_value;
		end
	end

	// Clamp and split
	always_comb begin
		num_lim  = four_digits(cfg) ? NumLimitFour : NumLimitTwo;
		num_cl   = (num_s1 > 16'(num_lim)) ? num_lim : num_s1[13:0];
		prod     = 28'(num_cl) * 28'(RecipHundred);
		hundreds = prod[RecipShift+6:RecipShift];
		rem_full = num_cl - 14'(hundreds) * 14'd100;
		hrs_cl   = (hrs_s1 > HoursLimit) ? HoursLimit : hrs_s1;
		min_cl   = (min_s1 > MinutesLimit) ? MinutesLimit : min_s1;

		pair_d.op = op_s1;
		case (op_s1)
			OP_SET_TIME: begin
				pair_d.hi = hrs_cl[6:0];
				pair_d.lo = min_cl[6:0];
			end
			default: begin
				pair_d.hi = hundreds;
				pair_d.lo = rem_full[6:0];
			end
		endcase
	end

	// Split register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pair_s2 <= pair_d;
		end
	end

	assign pair_valid = valid_s2;
	assign pair       = pair_s2;

endmodule

### sv/sssd_scan.sv
// ----------------------------------------------------------------------------
// sssd_scan: display state, tick counter and digit scan
// Holds the shown value as four decimal digits, counts ticks, scans one
// position per interval and registers the drive levels of every transaction.
// ----------------------------------------------------------------------------
module sssd_scan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              pair_valid,
	input  sssd_pkg::pair_t   pair,
	input  sssd_pkg::cfg_t    cfg,
	output logic              res_valid,
	output sssd_pkg::result_t res
);
	import sssd_pkg::*;

	// digit 3 = thousands .. digit 0 = ones
	bcd_t        digits_q [4];
	logic [15:0] tick_q;
	logic [1:0]  pos_q;
	logic [6:0]  seg_q;
	logic [3:0]  dig_q;

	bcd_t        digits_d [4];
	logic [15:0] tick_d;
	logic [1:0]  pos_d;
	logic [6:0]  seg_d;
	logic [3:0]  dig_d;

	logic        four;
	logic        slz;
	logic [15:0] tick_inc;
	logic        scan_hit;
	logic [1:0]  pos_cur;
	bcd_t        sel_digit;
	logic        blank;
	logic [7:0]  hi_split;
	logic [7:0]  lo_split;

	logic        valid_s3;
	result_t     res_s3;
	result_t     res_d;

	always_comb begin
		four     = four_digits(cfg);
		slz      = cfg.show_leading_zeros;
		tick_inc = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
		scan_hit = (tick_inc >= cfg.scan_interval);
		hi_split = split_tens(pair.hi);
		lo_split = split_tens(pair.lo);

		// Wrap a position left over from four-digit mode
		pos_cur = (!four && pos_q[1]) ? 2'd0 : pos_q;

		// Digit pick and leading-zero blanking
		if (four) begin
			case (pos_cur)
				2'd0: begin
					sel_digit = digits_q[3];
					blank = !slz && (digits_q[3] == 4'd0);
				end
				2'd1: begin
					sel_digit = digits_q[2];
					blank = !slz && (digits_q[3] == 4'd0) && (digits_q[2] == 4'd0);
				end
				2'd2: begin
					sel_digit = digits_q[1];
					blank = !slz && (digits_q[3] == 4'd0) && (digits_q[2] == 4'd0)
						&& (digits_q[1] == 4'd0);
				end
				default: begin
					sel_digit = digits_q[0];
					blank = 1'b0;
				end
			endcase
		end else if (!pos_cur[0]) begin
			sel_digit = digits_q[1];
			blank = !slz && (digits_q[3] == 4'd0) && (digits_q[2] == 4'd0)
				&& (digits_q[1] == 4'd0);
		end else begin
			sel_digit = digits_q[0];
			blank = 1'b0;
		end

		// Defaults: hold state
		digits_d = digits_q;
		tick_d   = tick_q;
		pos_d    = pos_q;
		seg_d    = seg_q;
		dig_d    = dig_q;

		case (pair.op)
			OP_TICK: begin
				tick_d = tick_inc;
				if (scan_hit) begin
					tick_d = 16'd0;
					pos_d  = four ? pos_cur + 2'd1 : {1'b0, ~pos_cur[0]};
					if (blank) begin
						seg_d = 7'd0;
						dig_d = 4'd0;
					end else begin
						seg_d = seg_pattern(sel_digit);
						dig_d = 4'b0001 << pos_cur;
					end
				end
			end
			OP_SET_NUMBER: begin
				digits_d[3] = hi_split[7:4];
				digits_d[2] = hi_split[3:0];
				digits_d[1] = lo_split[7:4];
				digits_d[0] = lo_split[3:0];
			end
			OP_SET_TIME: begin
				if (four) begin
					digits_d[3] = hi_split[7:4];
					digits_d[2] = hi_split[3:0];
					digits_d[1] = lo_split[7:4];
					digits_d[0] = lo_split[3:0];
				end
			end
			default: begin
				digits_d[3] = 4'd0;
				digits_d[2] = 4'd0;
				digits_d[1] = 4'd0;
				digits_d[0] = 4'd0;
				seg_d       = 7'd0;
				dig_d       = 4'd0;
			end
		endcase

		// Line levels with the configured polarity
		res_d.segment  = seg_d;
		res_d.lines    = cfg.common_cathode ? ~dig_d : dig_d;
		res_d.position = pos_d;
	end

	// Display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				digits_q[i] <= 4'd0;
			end
			tick_q <= 16'd0;
			pos_q  <= 2'd0;
			seg_q  <= 7'd0;
			dig_q  <= 4'd0;
		end else if (advance && pair_valid) begin
			digits_q <= digits_d;
			tick_q   <= tick_d;
			pos_q    <= pos_d;
			seg_q    <= seg_d;
			dig_q    <= dig_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pair_valid) begin
			res_s3 <= res_d;
		end
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule

### sv/seven_segment_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit: multiplexed 2/4-digit display driver
// Takes tick, set-number, set-time and clear transactions and returns the
// segment and digit line levels after each one.
// ----------------------------------------------------------------------------
// Usage: one input transaction is taken every cycle and each produces one
// result transaction through the input register, the clamp/split register
// and the result register. The only thing that holds off input is a
// result left waiting in the output register; in_ready follows out_ready
// while that register is full. The scan stage updates the display state
// once per transaction, which sets the one-per-cycle rate. Configuration
// writes are accepted every cycle and should be made while no transaction
// is in flight.
module seven_segment_scan_driver_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     operation,
	input  logic [15:0]                    number_value,
	input  logic [7:0]                     hours_value,
	input  logic [7:0]                     minutes_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [6:0]                     segment_drive,
	output logic [3:0]                     digit_drive,
	output logic [1:0]                     scan_position,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sssd_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import sssd_pkg::*;

	cfg_t    cfg_q;
	logic    advance;
	logic    pair_valid;
	pair_t   pair;
	logic    res_valid;
	result_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_digit_mode    <= 1'b1;
			cfg_q.show_leading_zeros <= 1'b0;
			cfg_q.common_cathode     <= 1'b1;
			cfg_q.scan_interval      <= ScanIntervalReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FOUR_DIGIT_MODE:    cfg_q.four_digit_mode    <= cfg_data[0];
				REG_SHOW_LEADING_ZEROS: cfg_q.show_leading_zeros <= cfg_data[0];
				REG_COMMON_CATHODE:     cfg_q.common_cathode     <= cfg_data[0];
				REG_SCAN_INTERVAL:      cfg_q.scan_interval      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Whole pipeline moves unless a result sits untaken
	assign advance  = !res_valid || out_ready;
	assign in_ready = advance;

	sssd_prep u_prep (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.in_valid      (in_valid),
		.operation     (operation),
		.number_value  (number_value),
		.hours_value   (hours_value),
		.minutes_value (minutes_value),
		.cfg           (cfg_q),
		.pair_valid    (pair_valid),
		.pair          (pair)
	);

	sssd_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.pair_valid (pair_valid),
		.pair       (pair),
		.cfg        (cfg_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_valid     = res_valid;
	assign segment_drive = res.segment;
	assign digit_drive   = res.lines;
	assign scan_position = res.position;

endmodule

### tb/sv/seven_segment_scan_driver_unit_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_unit_tb: self-checking bench for the scan driver
// Walks a short table of hand-picked transactions (clamps, blanking, mode
// and polarity changes, position wrap), then runs randomized phases under
// different register settings. Every accepted transaction is run through
// a local display predictor and each result is compared field by field.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_unit_tb;
	import sssd_pkg::*;

	localparam int CycleLimit   = 400000;
	localparam int SettleCycles = 6;
	localparam int TailCycles   = 12;
	localparam int NumPhases    = 9;
	localparam int PhaseItems   = 48;

	// Index past the last register, must be ignored
	localparam logic [CfgIndexW-1:0] REG_NONE = 8'd255;

	// Glyphs 0..9, seven bits each, digit 0 in the low bits
	localparam logic [69:0] Glyphs = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
		7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           operation;
	logic [15:0]          number_value;
	logic [7:0]           hours_value;
	logic [7:0]           minutes_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [6:0]           segment_drive;
	logic [3:0]           digit_drive;
	logic [1:0]           scan_position;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index;
	logic [15:0]          cfg_data;

	seven_segment_scan_driver_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.number_value  (number_value),
		.hours_value   (hours_value),
		.minutes_value (minutes_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.segment_drive (segment_drive),
		.digit_drive   (digit_drive),
		.scan_position (scan_position),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor copy of registers and display state
	logic        p_four;
	logic        p_zeros;
	logic        p_cathode;
	logic [15:0] p_interval;
	logic [13:0] disp_value;
	int unsigned tick_count;
	logic [1:0]  scan_pos;
	logic [6:0]  seg_latch;
	logic [3:0]  digit_mask;

	result_t pending_drive[$];
	int      mismatches;
	logic    steady;

	// One directed row: either a register write or an input transaction
	typedef struct {
		logic                 is_cfg;
		logic [CfgIndexW-1:0] reg_index;
		logic [15:0]          reg_data;
		op_t                  op;
		logic [15:0]          num;
		logic [7:0]           hrs;
		logic [7:0]           mins;
		logic                 has_exp;
		result_t              exp;
	} step_row_t;

	step_row_t steps[$];

	// Row with every field cleared
	function automatic step_row_t empty_row();
		step_row_t r;
		r.is_cfg = 1'b0;
		r.reg_index = '0;
		r.reg_data = '0;
		r.op = OP_TICK;
		r.num = '0;
		r.hrs = '0;
		r.mins = '0;
		r.has_exp = 1'b0;
		r.exp = '0;
		return r;
	endfunction

	function automatic void add_reg(input logic [CfgIndexW-1:0] idx, input logic [15:0] data);
		step_row_t r;
		r = empty_row();
		r.is_cfg = 1'b1;
		r.reg_index = idx;
		r.reg_data = data;
		r.op = OP_TICK;
		steps.push_back(r);
	endfunction

	function automatic void add_item(input op_t op, input logic [15:0] num,
			input logic [7:0] hrs, input logic [7:0] mins);
		step_row_t r;
		r = empty_row();
		r.op = op;
		r.num = num;
		r.hrs = hrs;
		r.mins = mins;
		steps.push_back(r);
	endfunction

	// Row whose result is obvious: display still dark after reset
	function automatic void add_dark(input op_t op, input logic [15:0] num,
			input logic [7:0] hrs, input logic [7:0] mins);
		step_row_t r;
		r = empty_row();
		r.op = op;
		r.num = num;
		r.hrs = hrs;
		r.mins = mins;
		r.has_exp = 1'b1;
		r.exp.segment = 7'h00;
		r.exp.lines = 4'hF;
		r.exp.position = 2'd0;
		steps.push_back(r);
	endfunction

	// Register write as seen by the predictor
	function automatic void apply_reg(input logic [CfgIndexW-1:0] idx, input logic [15:0] data);
		case (idx)
			REG_FOUR_DIGIT_MODE:    p_four = data[0];
			REG_SHOW_LEADING_ZEROS: p_zeros = data[0];
			REG_COMMON_CATHODE:     p_cathode = data[0];
			REG_SCAN_INTERVAL:      p_interval = data;
			default: ;
		endcase
	endfunction

	// Advance the display state by one transaction, return the drive levels
	function automatic result_t predict_drive(input op_t op, input logic [15:0] num,
			input logic [7:0] hrs, input logic [7:0] mins);
		int unsigned n;
		int unsigned div;
		int unsigned d;
		int unsigned lim;
		int unsigned h;
		int unsigned m;
		logic        blank;
		result_t     r;
		n = (p_four && MaxDigits >= 4) ? 4 : 2;
		case (op)
			OP_TICK: begin
				tick_count = tick_count + 1;
				if (tick_count > 65535) tick_count = 65535;
				if (tick_count >= p_interval) begin
					tick_count = 0;
					if (scan_pos >= n) scan_pos = 2'd0;
					// place value of the digit under scan
					if (n == 2) div = (scan_pos == 0) ? 10 : 1;
					else begin
						case (scan_pos)
							2'd0: div = 1000;
							2'd1: div = 100;
							2'd2: div = 10;
							default: div = 1;
						endcase
					end
					d = (disp_value / div) % 10;
					blank = !p_zeros && div > 1 && disp_value < div;
					if (blank) begin
						seg_latch = 7'h00;
						digit_mask = 4'h0;
					end else begin
						seg_latch = Glyphs[d*7 +: 7];
						digit_mask = 4'(1 << scan_pos);
					end
					scan_pos = 2'((scan_pos + 1) % n);
				end
			end
			OP_SET_NUMBER: begin
				lim = (n == 2) ? 99 : 9999;
				disp_value = 14'((num > lim) ? lim : num);
			end
			OP_SET_TIME: begin
				if (n == 4) begin
					h = (hrs > 23) ? 23 : hrs;
					m = (mins > 59) ? 59 : mins;
					disp_value = 14'(h * 100 + m);
				end
			end
			default: begin
				disp_value = '0;
				seg_latch = 7'h00;
				digit_mask = 4'h0;
			end
		endcase
		r.segment = seg_latch;
		r.lines = p_cathode ? ~digit_mask : digit_mask;
		r.position = scan_pos;
		return r;
	endfunction

	// Random idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 70) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one input transaction and record its expected result
	task automatic send_item(input op_t op, input logic [15:0] num, input logic [7:0] hrs,
			input logic [7:0] mins, input logic use_typed, input result_t typed);
		result_t r;
		in_valid <= 1'b1;
		operation <= op;
		number_value <= num;
		hours_value <= hrs;
		minutes_value <= mins;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_drive(op, num, hrs, mins);
		pending_drive.push_back(use_typed ? typed : r);
	endtask

	task automatic idle_gap();
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Stop offering input and wait until the pipeline has drained
	task automatic settle();
		if (in_valid) in_valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Register write; cfg_valid is left high for a following write
	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
	endtask

	// Receiver: random back-pressure on the result channel
	int stall_left;
	initial stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	// Result checker: compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				$error("unexpected result: segment_drive %h digit_drive %h scan_position %0d",
					segment_drive, digit_drive, scan_position);
				mismatches = mismatches + 1;
			end else begin
				e = pending_drive.pop_front();
				if (segment_drive !== e.segment) begin
					$error("segment_drive: expected %h, got %h", e.segment, segment_drive);
					mismatches = mismatches + 1;
				end
				if (digit_drive !== e.lines) begin
					$error("digit_drive: expected %h, got %h", e.lines, digit_drive);
					mismatches = mismatches + 1;
				end
				if (scan_position !== e.position) begin
					$error("scan_position: expected %0d, got %0d", e.position, scan_position);
					mismatches = mismatches + 1;
				end
			end
		end
	end

	// Watchdog
	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("seven_segment_scan_driver_unit regression: fail");
		$finish;
	end

	// Stimulus
	initial begin
		int      i;
		int      ph;
		int      k;
		int      r;
		op_t     op;
		logic [15:0] num;
		logic [7:0]  hrs;
		logic [7:0]  mins;
		logic [15:0] ivl;
		result_t none;

		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_TICK;
		number_value = '0;
		hours_value = '0;
		minutes_value = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		mismatches = 0;
		none = '0;

		p_four = 1'b1;
		p_zeros = 1'b0;
		p_cathode = 1'b1;
		p_interval = ScanIntervalReset;
		disp_value = '0;
		tick_count = 0;
		scan_pos = 2'd0;
		seg_latch = 7'h00;
		digit_mask = 4'h0;

		// Directed table
		add_dark(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_dark(OP_SET_NUMBER, 16'hFFFF, 8'h00, 8'h00);
		add_dark(OP_SET_TIME, 16'h0000, 8'hFF, 8'hFF);
		add_dark(OP_CLEAR, 16'hFFFF, 8'hFF, 8'hFF);
		// scan on every tick, all nines across the four positions
		add_reg(REG_SCAN_INTERVAL, 16'd0);
		add_item(OP_SET_NUMBER, 16'hFFFF, 8'h00, 8'h00);
		for (i = 0; i < 4; i++) add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_SET_TIME, 16'h0000, 8'd200, 8'd200);
		// zero value: leading digits blanked
		add_item(OP_SET_TIME, 16'h0000, 8'd0, 8'd0);
		add_item(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		// leading zeros shown, active-high digit lines
		add_reg(REG_SHOW_LEADING_ZEROS, 16'd1);
		add_reg(REG_COMMON_CATHODE, 16'hFFFE);
		add_reg(REG_SCAN_INTERVAL, 16'd1);
		add_item(OP_SET_NUMBER, 16'd7, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_CLEAR, 16'h0000, 8'h00, 8'h00);
		add_item(OP_SET_NUMBER, 16'd1234, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		// drop to two digits with position past the end and a large kept value
		add_reg(REG_FOUR_DIGIT_MODE, 16'hFFFE);
		add_reg(REG_SHOW_LEADING_ZEROS, 16'd0);
		add_reg(REG_NONE, 16'hFFFF);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_SET_TIME, 16'h0000, 8'd10, 8'd10);
		add_item(OP_SET_NUMBER, 16'hFFFF, 8'h00, 8'h00);
		add_item(OP_SET_NUMBER, 16'd5, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);
		add_item(OP_TICK, 16'h0000, 8'h00, 8'h00);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Walk the directed table
		for (i = 0; i < steps.size(); i++) begin
			if (steps[i].is_cfg) begin
				if (i == 0 || !steps[i-1].is_cfg) settle();
				write_reg(steps[i].reg_index, steps[i].reg_data);
				if (i + 1 == steps.size() || !steps[i+1].is_cfg) cfg_valid <= 1'b0;
			end else begin
				send_item(steps[i].op, steps[i].num, steps[i].hrs, steps[i].mins,
					steps[i].has_exp, steps[i].exp);
				idle_gap();
			end
		end

		// Random phases under varying register settings
		for (ph = 0; ph < NumPhases; ph++) begin
			settle();
			steady = (ph % 4 == 3);
			if (ph == 0) ivl = 16'hFFFF;
			else if (ph == 1) ivl = 16'd1;
			else if (ph == 2) ivl = 16'd0;
			else ivl = 16'($urandom_range(0, 6));
			write_reg(REG_FOUR_DIGIT_MODE, {15'($urandom), 1'(ph % 3 != 2)});
			write_reg(REG_SHOW_LEADING_ZEROS, {15'($urandom), 1'((ph >> 1) & 1)});
			write_reg(REG_COMMON_CATHODE, {15'($urandom), 1'(ph & 1)});
			write_reg(REG_SCAN_INTERVAL, ivl);
			write_reg(CfgIndexW'($urandom_range(4, 255)), 16'($urandom));
			cfg_valid <= 1'b0;

			for (k = 0; k < PhaseItems; k++) begin
				r = $urandom_range(0, 99);
				if (r < 55) op = OP_TICK;
				else if (r < 72) op = OP_SET_NUMBER;
				else if (r < 92) op = OP_SET_TIME;
				else op = OP_CLEAR;
				case ($urandom_range(0, 2))
					0: num = 16'($urandom);
					1: num = 16'($urandom_range(0, 120));
					default: num = 16'($urandom_range(0, 10000));
				endcase
				hrs = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 30));
				mins = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 70));
				send_item(op, num, hrs, mins, 1'b0, none);
				idle_gap();
				// occasionally hold input until every result is back
				if ($urandom_range(0, 39) == 0) settle();
			end
		end

		settle();
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0 && pending_drive.size() == 0)
			$display("seven_segment_scan_driver_unit regression: pass");
		else
			$display("seven_segment_scan_driver_unit regression: fail");
		$finish;
	end

endmodule
